@@ sv/srfr_pkg.sv @@
// Package for the sensor reply frame receiver.
// Holds frame constants, input mode codes and the captured frame struct.
// No dependencies.
package srfr_pkg;

  localparam int ByteW = 8;
  localparam int IdxW  = 4;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [IdxW-1:0]  idx_t;

  localparam idx_t  FrameLen = 4'd9;
  localparam idx_t  LastIdx  = 4'd8;
  localparam idx_t  SyncIdx  = 4'd1;
  localparam byte_t SyncByte = 8'hFF;
  localparam logic [8:0] TempBias = 9'd40;

  localparam logic ModeByte  = 1'b0;
  localparam logic ModeStart = 1'b1;

  typedef struct packed {
    logic [15:0] conc_raw;
    byte_t       temp_byte;
    byte_t       status;
    byte_t       sum;
    byte_t       rx_checksum;
  } frame_t;

endpackage

@@ sv/srfr_capture.sv @@
// Byte capture for the sensor reply frame receiver.
// Tracks the byte position, stores bytes 0..7 and flags the closing byte.
// Depends on srfr_pkg.
module srfr_capture (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  beat,
  input  logic                  mode,
  input  srfr_pkg::byte_t       rx_byte,
  output logic                  done,
  output srfr_pkg::frame_t      frame
);

  srfr_pkg::idx_t  idx;
  srfr_pkg::idx_t  idx_next;
  srfr_pkg::byte_t bytes [8];
  logic            store;
  logic            resync;

  assign store  = beat && (mode == srfr_pkg::ModeByte) && (idx < srfr_pkg::FrameLen);
  assign resync = (idx == srfr_pkg::SyncIdx) && (bytes[0] == srfr_pkg::SyncByte)
                  && (rx_byte == srfr_pkg::SyncByte);
  assign done   = store && (idx == srfr_pkg::LastIdx);

  always_comb begin
    idx_next = idx;
    if (beat && (mode == srfr_pkg::ModeStart)) begin
      idx_next = '0;
    end else if (store) begin
      if (resync) begin
        idx_next = srfr_pkg::SyncIdx;
      end else begin
        idx_next = idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= srfr_pkg::FrameLen;
    end else begin
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store && !idx[3]) begin
      bytes[idx[2:0]] <= rx_byte;
    end
  end

  always_comb begin
    frame.conc_raw    = {bytes[2], bytes[3]};
    frame.temp_byte   = bytes[4];
    frame.status      = bytes[5];
    frame.sum         = ((bytes[1] + bytes[2]) + (bytes[3] + bytes[4]))
                        + ((bytes[5] + bytes[6]) + bytes[7]);
    frame.rx_checksum = rx_byte;
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= srfr_pkg::FrameLen)
    else $error("byte position out of range");

  a_start: assert property (@(posedge clk) disable iff (rst)
    beat && (mode == srfr_pkg::ModeStart) |=> idx == '0)
    else $error("start beat did not rearm capture");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> idx == srfr_pkg::FrameLen)
    else $error("capture not idle after closing byte");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    beat && (mode == srfr_pkg::ModeByte) && (idx == srfr_pkg::FrameLen)
    |=> idx == srfr_pkg::FrameLen)
    else $error("byte left idle state");
`endif

endmodule

@@ sv/srfr_decode.sv @@
// Result decode and output register for the sensor reply frame receiver.
// Holds the calibration offset and forms concentration, temperature, checksum.
// Depends on srfr_pkg.
module srfr_decode (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [15:0]           cfg_write_data,
  input  logic                  done,
  input  srfr_pkg::frame_t      frame,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [15:0]           concentration,
  output logic signed [8:0]     temperature,
  output srfr_pkg::byte_t       status_bits,
  output srfr_pkg::byte_t       computed_checksum,
  output srfr_pkg::byte_t       received_checksum
);

  logic [15:0] cal_offset;
  logic        out_valid_next;

  always_comb begin
    out_valid_next = out_valid;
    if (done) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_offset <= '0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (cfg_write_en) begin
        cal_offset <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      concentration     <= frame.conc_raw - cal_offset;
      temperature       <= signed'({1'b0, frame.temp_byte} - srfr_pkg::TempBias);
      status_bits       <= frame.status;
      computed_checksum <= 8'd0 - frame.sum;
      received_checksum <= frame.rx_checksum;
    end
  end

endmodule

@@ sv/sensor_response_frame_receiver.sv @@
// Sensor reply frame receiver: one received byte or start command per beat.
// Throughput: one input beat per cycle; input stalls only while a result waits.
// The result is registered: out_valid rises in the cycle after the closing byte is accepted.
// Reset: capture idle (bytes ignored until a start beat), offset 0, no result.
// Depends on srfr_pkg, srfr_capture and srfr_decode.
module sensor_response_frame_receiver (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [15:0]           cfg_write_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  mode,
  input  logic [7:0]            rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           concentration,
  output logic signed [8:0]     temperature,
  output logic [7:0]            status_bits,
  output logic [7:0]            computed_checksum,
  output logic [7:0]            received_checksum
);

  logic             beat;
  logic             done;
  srfr_pkg::frame_t frame;

  assign in_ready = !out_valid || out_ready;
  assign beat     = in_valid && in_ready;

  srfr_capture u_capture (
    .clk     (clk),
    .rst     (rst),
    .beat    (beat),
    .mode    (mode),
    .rx_byte (rx_byte),
    .done    (done),
    .frame   (frame)
  );

  srfr_decode u_decode (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .done              (done),
    .frame             (frame),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .concentration     (concentration),
    .temperature       (temperature),
    .status_bits       (status_bits),
    .computed_checksum (computed_checksum),
    .received_checksum (received_checksum)
  );

endmodule

@@ verif/tb_sensor_response_frame_receiver.sv @@
// Testbench for sensor_response_frame_receiver: directed and random reply frames,
// decoded fields checked against a local frame decoder, random gaps on both sides.
// Depends on srfr_pkg and the receiver RTL.
`timescale 1ns / 100ps

module tb_sensor_response_frame_receiver;

  localparam int IdleLimit = 500;

  typedef struct {
    logic [15:0]       conc;
    logic signed [8:0] temp;
    srfr_pkg::byte_t   status;
    srfr_pkg::byte_t   calc_sum;
    srfr_pkg::byte_t   rx_sum;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [15:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = srfr_pkg::ModeByte;
  logic [7:0] rx_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] concentration;
  logic signed [8:0] temperature;
  logic [7:0] status_bits;
  logic [7:0] computed_checksum;
  logic [7:0] received_checksum;

  srfr_pkg::byte_t frame_store [0:srfr_pkg::LastIdx];
  srfr_pkg::idx_t  frame_pos = srfr_pkg::FrameLen;
  logic [15:0]     offset_model = '0;
  reading_t        pending_readings [$];
  reading_t        seen;
  bit              in_acc = 1'b0;
  bit              out_acc = 1'b0;
  bit              gaps_on = 1'b1;
  int              used_beats = 0;
  int              errors = 0;
  int              quiet_cycles = 0;

  sensor_response_frame_receiver i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .mode              (mode),
    .rx_byte           (rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .concentration     (concentration),
    .temperature       (temperature),
    .status_bits       (status_bits),
    .computed_checksum (computed_checksum),
    .received_checksum (received_checksum)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    in_acc = in_valid && in_ready;
    out_acc = out_valid && out_ready;
    seen.conc = concentration;
    seen.temp = temperature;
    seen.status = status_bits;
    seen.calc_sum = computed_checksum;
    seen.rx_sum = received_checksum;
  end

  always @(posedge clk) begin
    if (in_acc || out_acc) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IdleLimit) begin
      $display("tb_sensor_response_frame_receiver: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit decode_beat(input logic m, input srfr_pkg::byte_t b);
    reading_t        r;
    srfr_pkg::byte_t sum;
    int              i;
    if (m == srfr_pkg::ModeStart) begin
      frame_pos = '0;
      return 1'b1;
    end
    if (frame_pos >= srfr_pkg::FrameLen) return 1'b0;
    frame_store[frame_pos] = b;
    frame_pos = frame_pos + 1'b1;
    if (frame_pos == srfr_pkg::SyncIdx + 1'b1 && frame_store[0] == srfr_pkg::SyncByte
        && frame_store[1] == srfr_pkg::SyncByte)
      frame_pos = srfr_pkg::SyncIdx;
    if (frame_pos == srfr_pkg::FrameLen) begin
      sum = '0;
      for (i = 1; i <= 7; i++) sum += frame_store[i];
      r.conc = {frame_store[2], frame_store[3]} - offset_model;
      r.temp = {1'b0, frame_store[4]} - srfr_pkg::TempBias;
      r.status = frame_store[5];
      r.calc_sum = 8'hFF - sum + 8'h01;
      r.rx_sum = frame_store[srfr_pkg::LastIdx];
      pending_readings.push_back(r);
    end
    return 1'b1;
  endfunction

  function automatic srfr_pkg::byte_t pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return srfr_pkg::SyncByte;
      default: return srfr_pkg::byte_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic check_reading();
    reading_t want;
    if (pending_readings.size() == 0) begin
      report_mismatch("unexpected result", seen.conc, '0);
      return;
    end
    want = pending_readings.pop_front();
    if (seen.conc !== want.conc) report_mismatch("concentration", seen.conc, want.conc);
    if (seen.temp !== want.temp)
      report_mismatch("temperature", 16'(seen.temp), 16'(want.temp));
    if (seen.status !== want.status)
      report_mismatch("status_bits", 16'(seen.status), 16'(want.status));
    if (seen.calc_sum !== want.calc_sum)
      report_mismatch("computed_checksum", 16'(seen.calc_sum), 16'(want.calc_sum));
    if (seen.rx_sum !== want.rx_sum)
      report_mismatch("received_checksum", 16'(seen.rx_sum), 16'(want.rx_sum));
  endtask

  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_acc);
      check_reading();
    end
  end

  task automatic send_beat(input logic m, input srfr_pkg::byte_t b);
    int gap;
    gap = gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    rx_byte <= b;
    do @(posedge clk); while (!in_acc);
    if (decode_beat(m, b)) used_beats++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_offset(input logic [15:0] value);
    wait_for_results();
    repeat (4) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    offset_model = value;
  endtask

  task automatic send_frame();
    if ($urandom_range(0, 3) == 0) begin
      send_beat(srfr_pkg::ModeStart, pick_byte());
      repeat ($urandom_range(2, 4)) send_beat(srfr_pkg::ModeByte, srfr_pkg::SyncByte);
    end else begin
      send_beat(srfr_pkg::ModeStart, pick_byte());
    end
    while (frame_pos != srfr_pkg::FrameLen) send_beat(srfr_pkg::ModeByte, pick_byte());
  endtask

  task automatic send_broken_frame();
    send_beat(srfr_pkg::ModeStart, pick_byte());
    repeat ($urandom_range(0, 7)) send_beat(srfr_pkg::ModeByte, pick_byte());
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4))
      send_beat(($urandom_range(0, 3) == 0) ? srfr_pkg::ModeStart : srfr_pkg::ModeByte,
                pick_byte());
  endtask

  // Bytes outside a capture are dropped after reset.
  task automatic test_idle_bytes();
    send_beat(srfr_pkg::ModeByte, 8'h00);
  endtask

  // Repeated sync header, widest field values, then a stray byte once idle.
  task automatic test_sync_header();
    srfr_pkg::byte_t seq [11] = '{8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hFF, 8'hFF, 8'hFF,
                                  8'h00, 8'h7F, 8'h80, 8'h00};
    send_beat(srfr_pkg::ModeStart, 8'h00);
    foreach (seq[k]) send_beat(srfr_pkg::ModeByte, seq[k]);
    send_beat(srfr_pkg::ModeByte, srfr_pkg::SyncByte);
  endtask

  // Restart mid-frame, largest offset, lowest temperature byte.
  task automatic test_restart();
    srfr_pkg::byte_t seq [9] = '{8'hA5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h01,
                                 8'hFE, 8'h5A};
    write_offset(16'hFFFF);
    send_beat(srfr_pkg::ModeStart, srfr_pkg::SyncByte);
    send_beat(srfr_pkg::ModeByte, 8'h55);
    send_beat(srfr_pkg::ModeStart, 8'hC3);
    foreach (seq[k]) send_beat(srfr_pkg::ModeByte, seq[k]);
  endtask

  task automatic test_random_traffic();
    logic [15:0] offsets [4];
    int goal;
    int pick;
    offsets[0] = 16'h0000;
    offsets[1] = 16'($urandom);
    offsets[2] = 16'hFFFF;
    offsets[3] = 16'($urandom_range(1, 255));
    foreach (offsets[p]) begin
      write_offset(offsets[p]);
      goal = used_beats + 100;
      while (used_beats < goal) begin
        if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
        pick = $urandom_range(0, 19);
        if (pick < 14) send_frame();
        else if (pick < 16) send_broken_frame();
        else if (pick < 18) send_noise();
        else if (pick == 18)
          repeat ($urandom_range(1, 3)) send_beat(srfr_pkg::ModeByte, pick_byte());
        else wait_for_results();
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_idle_bytes();
    test_sync_header();
    test_restart();
    test_random_traffic();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_sensor_response_frame_receiver: PASS");
    end else begin
      $display("tb_sensor_response_frame_receiver: FAIL");
    end
    $finish;
  end

endmodule
